FILE: src/minifloat_to_fixed_decoder_core_assert.svh
// Assertion macros for the minifloat decoder core.
`ifndef MINIFLOAT_TO_FIXED_DECODER_CORE_ASSERT_SVH
`define MINIFLOAT_TO_FIXED_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfd assertion failed");

// Next-cycle implication, checked out of reset.
`define MFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfd assertion failed");

`endif

FILE: src/mfd_pkg.sv
// Shared types and constants for the minifloat decoder.
package mfd_pkg;

  localparam int RAW_W   = 16;
  localparam int FRAC_W  = 10;
  localparam int EXP_W   = 5;
  localparam int MANT_W  = FRAC_W + 1;
  localparam int SHIFT_W = 6;
  localparam int MAG_W   = 40;
  localparam int CLS_W   = 3;
  localparam int FRAC_POINT = 24;

  localparam logic [3:0] FRAC_W_MIN = 4'd2;
  localparam logic [3:0] FRAC_W_MAX = 4'd10;
  localparam logic [2:0] EXP_W_MIN  = 3'd3;
  localparam logic [2:0] EXP_W_MAX  = 3'd5;

  localparam logic [0:0] CFG_FRAC_WIDTH = 1'b0;
  localparam logic [0:0] CFG_EXP_WIDTH  = 1'b1;

  localparam logic [CLS_W-1:0] CLS_FINITE = 3'd0;
  localparam logic [CLS_W-1:0] CLS_PINF   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_MINF   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_NAN    = 3'd3;
  localparam logic [CLS_W-1:0] CLS_WIDE   = 3'd4;

  // Per-stage load enables.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } adv_t;

endpackage

FILE: src/mfd_datapath.sv
// Four-stage decode datapath: width clamp and capture, field split, classify, mantissa align.
module mfd_datapath import mfd_pkg::*; (
  input  logic                 clk,
  input  adv_t                 adv,
  input  logic [RAW_W-1:0]     raw_pattern,
  input  logic [3:0]           frac_width,
  input  logic [2:0]           exp_width,
  output logic [CLS_W-1:0]     value_class,
  output logic                 sign_bit,
  output logic [MAG_W-1:0]     magnitude
);

  // stage 1: capture
  logic [RAW_W-1:0] raw1_r;
  logic [3:0]       f1_r;
  logic [2:0]       e1_r;
  logic [3:0]       f_clamp;
  logic [2:0]       e_clamp;

  always_comb begin
    if (frac_width < FRAC_W_MIN) f_clamp = FRAC_W_MIN;
    else if (frac_width > FRAC_W_MAX) f_clamp = FRAC_W_MAX;
    else f_clamp = frac_width;
    if (exp_width < EXP_W_MIN) e_clamp = EXP_W_MIN;
    else if (exp_width > EXP_W_MAX) e_clamp = EXP_W_MAX;
    else e_clamp = exp_width;
  end

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      raw1_r <= raw_pattern;
      f1_r   <= f_clamp;
      e1_r   <= e_clamp;
    end
  end

  // stage 2: field extraction and width check
  logic [4:0]        total;
  logic [RAW_W:0]    over;
  logic [MANT_W-1:0] fmask;
  logic [EXP_W:0]    emask1;
  logic [RAW_W-1:0]  exp_sh;
  logic [3:0]        sign_idx;
  logic              wide2_r;
  logic              sign2_r;
  logic [FRAC_W-1:0] frac2_r;
  logic [EXP_W-1:0]  expo2_r;
  logic [3:0]        f2_r;
  logic [2:0]        e2_r;

  always_comb begin
    total    = 5'd1 + 5'(e1_r) + 5'(f1_r);
    over     = {1'b0, raw1_r} >> total;
    fmask    = (MANT_W'(1) << f1_r) - MANT_W'(1);
    emask1   = ((EXP_W + 1)'(1) << e1_r) - (EXP_W + 1)'(1);
    exp_sh   = raw1_r >> f1_r;
    sign_idx = f1_r + 4'(e1_r);
  end

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      wide2_r <= (over != '0);
      sign2_r <= raw1_r[sign_idx];
      frac2_r <= raw1_r[FRAC_W-1:0] & fmask[FRAC_W-1:0];
      expo2_r <= exp_sh[EXP_W-1:0] & emask1[EXP_W-1:0];
      f2_r    <= f1_r;
      e2_r    <= e1_r;
    end
  end

  // stage 3: classify, build mantissa and shift amount
  logic [EXP_W:0]     ones1;
  logic [EXP_W-1:0]   bias;
  logic               top_exp;
  logic               zero_exp;
  logic [EXP_W-1:0]   expo_eff;
  logic [6:0]         shift_full;
  logic [CLS_W-1:0]   cls3;
  logic [CLS_W-1:0]   cls3_r;
  logic               sign3_r;
  logic [MANT_W-1:0]  mant3;
  logic [MANT_W-1:0]  mant3_r;
  logic [SHIFT_W-1:0] shift3_r;

  always_comb begin
    ones1    = ((EXP_W + 1)'(1) << e2_r) - (EXP_W + 1)'(1);
    bias     = (EXP_W'(1) << (e2_r - 3'd1)) - EXP_W'(1);
    top_exp  = (expo2_r == ones1[EXP_W-1:0]);
    zero_exp = (expo2_r == '0);
    expo_eff = zero_exp ? EXP_W'(1) : expo2_r;
    shift_full = 7'(FRAC_POINT) + 7'(expo_eff) - 7'(bias) - 7'(f2_r);
    if (wide2_r) cls3 = CLS_WIDE;
    else if (top_exp) begin
      if (frac2_r != '0) cls3 = CLS_NAN;
      else if (sign2_r) cls3 = CLS_MINF;
      else cls3 = CLS_PINF;
    end else cls3 = CLS_FINITE;
    if (cls3 != CLS_FINITE) mant3 = '0;
    else if (zero_exp) mant3 = {1'b0, frac2_r};
    else mant3 = (MANT_W'(1) << f2_r) | {1'b0, frac2_r};
  end

  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      cls3_r   <= cls3;
      sign3_r  <= (cls3 == CLS_FINITE || cls3 == CLS_MINF) ? sign2_r : 1'b0;
      mant3_r  <= mant3;
      shift3_r <= shift_full[SHIFT_W-1:0];
    end
  end

  // stage 4: align into fixed point
  logic [47:0]      mag_wide;
  logic [CLS_W-1:0] cls4_r;
  logic             sign4_r;
  logic [MAG_W-1:0] mag4_r;

  assign mag_wide = 48'(mant3_r) << shift3_r;

  always_ff @(posedge clk) begin
    if (adv.ld4) begin
      cls4_r  <= cls3_r;
      sign4_r <= sign3_r;
      mag4_r  <= mag_wide[MAG_W-1:0];
    end
  end

  assign value_class = cls4_r;
  assign sign_bit    = sign4_r;
  assign magnitude   = mag4_r;

endmodule

FILE: src/minifloat_to_fixed_decoder_core.sv
// Top level of the minifloat to fixed-point decoder core.
// An input transfer passes through the stage 1, 2, 3 and 4 registers; out_valid is the stage 4 valid bit.
// Throughput: one pattern per cycle while out_ready is not held low; four register stages, each with its own valid bit.
// A stalled stage only holds back stages behind it, so bubbles are squeezed out.
// Reset (rst_n low, synchronous) clears all valid bits and sets widths to 10 and 5.
`include "minifloat_to_fixed_decoder_core_assert.svh"
module minifloat_to_fixed_decoder_core import mfd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] in_raw_pattern,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CLS_W-1:0] out_value_class,
  output logic             out_sign_bit,
  output logic [MAG_W-1:0] out_magnitude,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [3:0]       cfg_data
);

  logic [3:0] frac_width_r;
  logic [2:0] exp_width_r;
  logic       v1_r, v2_r, v3_r, v4_r;
  logic       rdy1, rdy2, rdy3, rdy4;
  adv_t       adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_width_r <= FRAC_W_MAX;
      exp_width_r  <= EXP_W_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAC_WIDTH: frac_width_r <= cfg_data;
        CFG_EXP_WIDTH:  exp_width_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign adv.ld1 = rdy1;
  assign adv.ld2 = rdy2;
  assign adv.ld3 = rdy3;
  assign adv.ld4 = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign in_ready  = rdy1;
  assign out_valid = v4_r;

  mfd_datapath u_datapath (
    .clk         (clk),
    .adv         (adv),
    .raw_pattern (in_raw_pattern),
    .frac_width  (frac_width_r),
    .exp_width   (exp_width_r),
    .value_class (out_value_class),
    .sign_bit    (out_sign_bit),
    .magnitude   (out_magnitude)
  );

  `MFD_ASSERT_NOW(a_mag_zero_unless_finite, out_valid && out_value_class != CLS_FINITE, out_magnitude == '0)
  `MFD_ASSERT_NOW(a_sign_clear_nan_wide, out_valid && (out_value_class == CLS_NAN || out_value_class == CLS_WIDE), !out_sign_bit)
  `MFD_ASSERT_NOW(a_inf_sign, out_valid && (out_value_class == CLS_PINF || out_value_class == CLS_MINF), out_sign_bit == (out_value_class == CLS_MINF))
  `MFD_ASSERT_NOW(a_class_range, out_valid, out_value_class <= CLS_WIDE)
  `MFD_ASSERT_NEXT(a_stage3_moves, v3_r && rdy4, v4_r)

endmodule
